@@ rtl/oblu_pkg.sv @@
package oblu_pkg;

  localparam int unsigned LevelCapacity = 64;
  localparam int unsigned PriceBits     = 32;
  localparam int unsigned AmountBits    = 48;
  localparam int unsigned CountBits     = 7;

  localparam logic [1:0] ActInsert    = 2'd0;
  localparam logic [1:0] ActOverwrite = 2'd1;
  localparam logic [1:0] ActDelete    = 2'd2;
  localparam logic [1:0] ActAbsent    = 2'd3;

  // Command broadcast to every cell of one side
  typedef struct packed {
    logic                  ins;   // shift down from insert point
    logic                  del;   // shift up from delete point
    logic                  ovw;   // overwrite amount at match
    logic [PriceBits-1:0]  price;
    logic [AmountBits-1:0] amount;
  } cell_cmd_t;

  // Status returned by one cell
  typedef struct packed {
    logic ahead;  // held price ranks strictly ahead of the probe
    logic match;  // held price equals the probe
  } cell_stat_t;

endpackage

@@ rtl/oblu_cell.sv @@
module oblu_cell (
  input  logic                                clk_i,
  input  logic                                side_i,
  input  logic                                en_i,      // entry lies below the count
  input  logic                                prev_en_i, // previous entry valid; prev_ahead_i: previous entry ahead
  input  logic                                prev_ahead_i,
  input  logic                                next_valid_i,
  input  oblu_pkg::cell_cmd_t                 cmd_i,
  input  logic [oblu_pkg::PriceBits-1:0]      prev_price_i,
  input  logic [oblu_pkg::AmountBits-1:0]     prev_amount_i,
  input  logic [oblu_pkg::PriceBits-1:0]      next_price_i,
  input  logic [oblu_pkg::AmountBits-1:0]     next_amount_i,
  output logic [oblu_pkg::PriceBits-1:0]      price_o,
  output logic [oblu_pkg::AmountBits-1:0]     amount_o,
  output oblu_pkg::cell_stat_t                stat_o
);

  logic [oblu_pkg::PriceBits-1:0]  price_q, price_d;
  logic [oblu_pkg::AmountBits-1:0] amount_q, amount_d;
  logic                            here_ahead, prev_ahead;

  assign here_ahead   = en_i & (side_i ? (price_q < cmd_i.price) : (price_q > cmd_i.price));
  assign prev_ahead   = prev_en_i & prev_ahead_i;
  assign stat_o.ahead = here_ahead;
  assign stat_o.match = en_i & (price_q == cmd_i.price);
  assign price_o      = price_q;
  assign amount_o     = amount_q;

  always_comb begin
    price_d  = price_q;
    amount_d = amount_q;
    if (cmd_i.ins && !here_ahead) begin
      // take the new level at the insert point, else the neighbour above
      if (prev_ahead || !prev_en_i) begin
        price_d  = cmd_i.price;
        amount_d = cmd_i.amount;
      end else begin
        price_d  = prev_price_i;
        amount_d = prev_amount_i;
      end
    end else if (cmd_i.del && !here_ahead && next_valid_i) begin
      price_d  = next_price_i;
      amount_d = next_amount_i;
    end else if (cmd_i.ovw && stat_o.match) begin
      amount_d = cmd_i.amount;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    amount_q <= amount_d;
  end

endmodule

@@ rtl/oblu_side.sv @@
module oblu_side (
  input  logic                                clk_i,
  input  logic                                side_i,
  input  logic [oblu_pkg::CountBits-1:0]      count_i,
  input  oblu_pkg::cell_cmd_t                 cmd_i,
  output logic [oblu_pkg::LevelCapacity-1:0]  ahead_o,
  output logic [oblu_pkg::LevelCapacity-1:0]  match_o,
  output logic [oblu_pkg::PriceBits-1:0]      best_price_o,
  output logic [oblu_pkg::AmountBits-1:0]     best_amount_o,
  output logic [oblu_pkg::PriceBits-1:0]      last_price_o
);

  localparam int unsigned N = oblu_pkg::LevelCapacity;

  logic [oblu_pkg::PriceBits-1:0]  prices  [N];
  logic [oblu_pkg::AmountBits-1:0] amounts [N];
  logic [N-1:0]                    en;
  oblu_pkg::cell_stat_t            stat [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                            pen, pah, nval;
    logic [oblu_pkg::PriceBits-1:0]  pp, np;
    logic [oblu_pkg::AmountBits-1:0] pa, na;
    assign en[g] = ({1'b0, count_i} > (oblu_pkg::CountBits+1)'(g));
    if (g == 0) begin : g_first
      assign pen = 1'b0;
      assign pah = 1'b0;
      assign pp  = '0;
      assign pa  = '0;
    end else begin : g_mid
      assign pen = en[g-1];
      assign pah = stat[g-1].ahead;
      assign pp  = prices[g-1];
      assign pa  = amounts[g-1];
    end
    if (g == N-1) begin : g_last
      assign nval = 1'b0;
      assign np   = '0;
      assign na   = '0;
    end else begin : g_inner
      assign nval = 1'b1;
      assign np   = prices[g+1];
      assign na   = amounts[g+1];
    end
    oblu_cell u_cell (
      .clk_i, .side_i, .en_i(en[g]),
      .prev_en_i(pen), .prev_ahead_i(pah), .next_valid_i(nval), .cmd_i,
      .prev_price_i(pp), .prev_amount_i(pa), .next_price_i(np), .next_amount_i(na),
      .price_o(prices[g]), .amount_o(amounts[g]), .stat_o(stat[g])
    );
    assign ahead_o[g] = stat[g].ahead & en[g];
    assign match_o[g] = stat[g].match & en[g];
  end

  assign best_price_o  = prices[0];
  assign best_amount_o = amounts[0];
  assign last_price_o  = prices[count_i[$clog2(N)-1:0] - 1'b1];

endmodule

@@ rtl/order_book_level_update_core.sv @@
// Order book level table: two sorted chains of 64 cells (bids best = highest first,
// asks best = lowest first). Raise start while busy is low with side, price and
// amount; exactly one result appears on the result ports after the compare and
// shift states, with valid_o high for a single cycle. The receiver cannot stall:
// capture the transaction on that cycle. Each update passes a compare state that
// checks the price against every cell in parallel, then a shift state that moves
// the chain by one place (insert, delete) or rewrites one amount; the result is
// shown in the cycle after. busy is high in both states and start is taken only
// while busy is low. A depth write (depth_wr_i) loads the limit, and idle cycles
// trim both side counts to it; issue it only while idle.
module order_book_level_update_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                depth_wr_i,
  input  logic [6:0]                          depth_limit_i,
  input  logic                                side_i,
  input  logic [oblu_pkg::PriceBits-1:0]      price_ticks_i,
  input  logic [oblu_pkg::AmountBits-1:0]     amount_i,
  output logic                                valid_o,
  output logic [1:0]                          action_o,
  output logic                                dropped_o,
  output logic [oblu_pkg::PriceBits-1:0]      dropped_price_o,
  output logic                                capacity_hit_o,
  output logic [oblu_pkg::CountBits-1:0]      level_count_o,
  output logic [oblu_pkg::PriceBits-1:0]      best_price_o,
  output logic [oblu_pkg::AmountBits-1:0]     best_amount_o,
  output logic                                book_empty_o
);

  localparam int unsigned N  = oblu_pkg::LevelCapacity;
  localparam int unsigned CB = oblu_pkg::CountBits;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StCompare = 2'd1;
  localparam logic [1:0] StShift   = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [6:0]    depth_q;
  logic [CB-1:0] bid_cnt_q, ask_cnt_q, lim, cnt_sel, cnt_new;
  logic          cap_lim;
  logic          side_q;
  logic [oblu_pkg::PriceBits-1:0]  price_q;
  logic [oblu_pkg::AmountBits-1:0] amount_q;

  logic [N-1:0] ahead_b, ahead_a, match_b, match_a, ahead_s, match_s;
  logic [oblu_pkg::PriceBits-1:0]  best_p_b, best_p_a, last_b, last_a, last_s;
  logic [oblu_pkg::AmountBits-1:0] best_m_b, best_m_a;
  oblu_pkg::cell_cmd_t cmd_b, cmd_a, cmd;

  // result staging
  logic [1:0] act_q;
  logic       drop_q, cap_q;
  logic [oblu_pkg::PriceBits-1:0] dprice_q;
  logic       ins_q, del_q, ovw_q;

  assign cap_lim = (depth_q == '0) || (depth_q > CB'(N));
  assign lim     = cap_lim ? CB'(N) : depth_q;
  assign cnt_sel = side_q ? ask_cnt_q : bid_cnt_q;
  assign busy    = (state_q != StIdle);

  oblu_side u_bid (
    .clk_i, .side_i(1'b0), .count_i(bid_cnt_q), .cmd_i(cmd_b),
    .ahead_o(ahead_b), .match_o(match_b), .best_price_o(best_p_b),
    .best_amount_o(best_m_b), .last_price_o(last_b)
  );
  oblu_side u_ask (
    .clk_i, .side_i(1'b1), .count_i(ask_cnt_q), .cmd_i(cmd_a),
    .ahead_o(ahead_a), .match_o(match_a), .best_price_o(best_p_a),
    .best_amount_o(best_m_a), .last_price_o(last_a)
  );

  assign ahead_s = side_q ? ahead_a : ahead_b;
  assign match_s = side_q ? match_a : match_b;
  assign last_s  = side_q ? last_a : last_b;

  always_comb begin
    cmd        = '0;
    cmd.price  = price_q;
    cmd.amount = amount_q;
    if (state_q == StShift) begin
      cmd.ins = ins_q;
      cmd.del = del_q;
      cmd.ovw = ovw_q;
    end
    cmd_b = cmd;
    cmd_a = cmd;
    if (side_q) begin
      cmd_b.ins = 1'b0; cmd_b.del = 1'b0; cmd_b.ovw = 1'b0;
    end else begin
      cmd_a.ins = 1'b0; cmd_a.del = 1'b0; cmd_a.ovw = 1'b0;
    end
  end

  always_comb begin
    cnt_new = cnt_sel;
    if (ins_q && !drop_q) cnt_new = cnt_sel + 1'b1;
    if (del_q)            cnt_new = cnt_sel - 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (start) state_d = StCompare;
      StCompare: state_d = StShift;
      StShift:   state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      depth_q   <= '0;
      bid_cnt_q <= '0;
      ask_cnt_q <= '0;
      valid_o   <= 1'b0;
      ins_q     <= 1'b0;
      del_q     <= 1'b0;
      ovw_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_o <= (state_q == StShift);
      if (depth_wr_i) begin
        depth_q <= depth_limit_i;
      end else if (state_q == StIdle) begin
        // hold counts within the limit in force
        if (bid_cnt_q > lim) bid_cnt_q <= lim;
        if (ask_cnt_q > lim) ask_cnt_q <= lim;
      end
      if (state_q == StCompare) begin
        ovw_q <= (|match_s) && (amount_q != '0);
        del_q <= (|match_s) && (amount_q == '0);
        ins_q <= !(|match_s) && (amount_q != '0);
      end
      if (state_q == StShift) begin
        if (side_q) ask_cnt_q <= cnt_new;
        else        bid_cnt_q <= cnt_new;
        ins_q <= 1'b0;
        del_q <= 1'b0;
        ovw_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      side_q   <= side_i;
      price_q  <= price_ticks_i;
      amount_q <= amount_i;
    end
    if (state_q == StCompare) begin
      drop_q   <= !(|match_s) && (amount_q != '0) && (cnt_sel >= lim);
      cap_q    <= !(|match_s) && (amount_q != '0) && (cnt_sel >= lim) && cap_lim;
      dprice_q <= ($countones(ahead_s) == int'(cnt_sel)) ? price_q : last_s;
      act_q    <= (|match_s) ? ((amount_q != '0) ? oblu_pkg::ActOverwrite
                                                 : oblu_pkg::ActDelete)
                             : ((amount_q != '0) ? oblu_pkg::ActInsert
                                                 : oblu_pkg::ActAbsent);
    end
  end

  // a full side drops the last cell naturally, or skips insert if new is worst
  assign action_o        = act_q;
  assign dropped_o       = drop_q;
  assign dropped_price_o = drop_q ? dprice_q : '0;
  assign capacity_hit_o  = cap_q;
  assign level_count_o   = side_q ? ask_cnt_q : bid_cnt_q;
  assign best_price_o    = (level_count_o == '0) ? '0 : (side_q ? best_p_a : best_p_b);
  assign best_amount_o   = (level_count_o == '0) ? '0 : (side_q ? best_m_a : best_m_b);
  assign book_empty_o    = (bid_cnt_q == '0) && (ask_cnt_q == '0);

  a_valid_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |=> valid_o)
    else $error("result strobe missing after shift");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == StIdle))
    else $error("result outside idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_cnt_q <= CB'(N)) && (ask_cnt_q <= CB'(N)))
    else $error("count beyond capacity");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic                            side;
    logic [oblu_pkg::PriceBits-1:0]  price;
    logic [oblu_pkg::AmountBits-1:0] amount;
  } update_t;

  typedef struct packed {
    logic [1:0]                      action;
    logic                            dropped;
    logic [oblu_pkg::PriceBits-1:0]  dropped_price;
    logic                            cap_hit;
    logic [oblu_pkg::CountBits-1:0]  count;
    logic [oblu_pkg::PriceBits-1:0]  best_price;
    logic [oblu_pkg::AmountBits-1:0] best_amount;
    logic                            empty;
  } level_report_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic                            depth_wr_i = 1'b0;
  logic [6:0]                      depth_limit_i = '0;
  logic                            side_i = 1'b0;
  logic [oblu_pkg::PriceBits-1:0]  price_ticks_i = '0;
  logic [oblu_pkg::AmountBits-1:0] amount_i = '0;
  logic                            valid_o;
  logic [1:0]                      action_o;
  logic                            dropped_o;
  logic [oblu_pkg::PriceBits-1:0]  dropped_price_o;
  logic                            capacity_hit_o;
  logic [oblu_pkg::CountBits-1:0]  level_count_o;
  logic [oblu_pkg::PriceBits-1:0]  best_price_o;
  logic [oblu_pkg::AmountBits-1:0] best_amount_o;
  logic                            book_empty_o;

  order_book_level_update_core dut (
    .clk_i, .rst_ni, .start, .busy, .depth_wr_i, .depth_limit_i,
    .side_i, .price_ticks_i, .amount_i, .valid_o, .action_o, .dropped_o,
    .dropped_price_o, .capacity_hit_o, .level_count_o, .best_price_o,
    .best_amount_o, .book_empty_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow book: index 0 is the best level of each side
  logic [oblu_pkg::PriceBits-1:0]  shadow_px[2][oblu_pkg::LevelCapacity];
  logic [oblu_pkg::AmountBits-1:0] shadow_amt[2][oblu_pkg::LevelCapacity];
  int unsigned           shadow_cnt[2];
  int unsigned           shadow_depth;

  update_t       pending_updates[$];
  level_report_t expected_reports[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   reports_seen = 0;
  int unsigned   drops_seen = 0;
  bit            hold_sender = 1'b0;

  function automatic int unsigned depth_in_force();
    return (shadow_depth == 0 || shadow_depth > oblu_pkg::LevelCapacity)
           ? oblu_pkg::LevelCapacity : shadow_depth;
  endfunction

  function automatic void apply_depth(logic [6:0] d);
    shadow_depth = d;
    for (int s = 0; s < 2; s++)
      if (shadow_cnt[s] > depth_in_force()) shadow_cnt[s] = depth_in_force();
  endfunction

  // Apply one update to the shadow book and return the report it should give
  function automatic level_report_t book_update(update_t u);
    level_report_t r;
    int unsigned   s, lim, n, pos;
    s   = u.side;
    lim = depth_in_force();
    r   = '0;
    if (shadow_cnt[s] > lim) shadow_cnt[s] = lim;
    n   = shadow_cnt[s];
    pos = 0;
    while (pos < n && (s ? shadow_px[s][pos] < u.price : shadow_px[s][pos] > u.price))
      pos++;
    if (pos < n && shadow_px[s][pos] == u.price) begin
      if (u.amount != 0) begin
        shadow_amt[s][pos] = u.amount;
        r.action = oblu_pkg::ActOverwrite;
      end else begin
        for (int i = pos; i < n - 1; i++) begin
          shadow_px[s][i]  = shadow_px[s][i+1];
          shadow_amt[s][i] = shadow_amt[s][i+1];
        end
        shadow_cnt[s] = n - 1;
        r.action = oblu_pkg::ActDelete;
      end
    end else if (u.amount == 0) begin
      r.action = oblu_pkg::ActAbsent;
    end else begin
      r.action = oblu_pkg::ActInsert;
      if (n < lim) begin
        for (int i = n; i > pos; i--) begin
          shadow_px[s][i]  = shadow_px[s][i-1];
          shadow_amt[s][i] = shadow_amt[s][i-1];
        end
        shadow_px[s][pos]  = u.price;
        shadow_amt[s][pos] = u.amount;
        shadow_cnt[s] = n + 1;
      end else begin
        r.dropped = 1'b1;
        r.cap_hit = (shadow_depth == 0 || shadow_depth > oblu_pkg::LevelCapacity);
        if (pos >= n) begin
          r.dropped_price = u.price;
        end else begin
          r.dropped_price = shadow_px[s][n-1];
          for (int i = n - 1; i > pos; i--) begin
            shadow_px[s][i]  = shadow_px[s][i-1];
            shadow_amt[s][i] = shadow_amt[s][i-1];
          end
          shadow_px[s][pos]  = u.price;
          shadow_amt[s][pos] = u.amount;
        end
      end
    end
    r.count = oblu_pkg::CountBits'(shadow_cnt[s]);
    if (shadow_cnt[s] > 0) begin
      r.best_price  = shadow_px[s][0];
      r.best_amount = shadow_amt[s][0];
    end
    r.empty = (shadow_cnt[0] == 0 && shadow_cnt[1] == 0);
    return r;
  endfunction

  function automatic update_t mk(logic sd, logic [oblu_pkg::PriceBits-1:0] p,
                                 logic [oblu_pkg::AmountBits-1:0] a);
    update_t u;
    u.side = sd; u.price = p; u.amount = a;
    return u;
  endfunction

  // Prices mostly from a narrow band so that hits, deletes and full sides are common
  function automatic update_t random_update(int unsigned band);
    update_t u;
    u.side  = 1'($urandom_range(0, 1));
    u.price = ($urandom_range(0, 9) == 0) ? {$urandom} : 32'd1000 + $urandom_range(0, band);
    case ($urandom_range(0, 5))
      0, 1:    u.amount = '0;
      2:       u.amount = 48'({$urandom, $urandom}) | 48'd1;
      default: u.amount = $urandom_range(1, 5000);
    endcase
    return u;
  endfunction

  // Driver: bursts of transactions with random gaps; the book is predicted on acceptance
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) expected_reports.push_back(book_update(mk(side_i,
        price_ticks_i, amount_i)));
    if (!rst_ni || (start && !busy) || !start) begin
      if (pending_updates.size() == 0 || hold_sender || !rst_ni) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else begin
        start         <= 1'b1;
        side_i        <= pending_updates[0].side;
        price_ticks_i <= pending_updates[0].price;
        amount_i      <= pending_updates[0].amount;
        void'(pending_updates.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: compare each strobe against the oldest prediction
  always @(posedge clk_i) begin
    level_report_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_o) begin
      got = {action_o, dropped_o, dropped_price_o, capacity_hit_o, level_count_o,
             best_price_o, best_amount_o, book_empty_o};
      reports_seen <= reports_seen + 1;
      if (dropped_o) drops_seen <= drops_seen + 1;
      if (expected_reports.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", got);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Wait for the book to settle, then write a new depth
  task automatic idle_then_depth(logic [6:0] d);
    while (pending_updates.size() != 0 || start || busy || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    depth_wr_i    <= 1'b1;
    depth_limit_i <= d;
    @(posedge clk_i);
    apply_depth(d);
    depth_wr_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [6:0] depths[6];
    depths = '{7'd1, 7'd64, 7'd3, 7'd127, 7'd8, 7'd0};
    shadow_cnt   = '{0, 0};
    shadow_depth = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty deletes, extremes, overwrite, delete, worst-level drop
    pending_updates.push_back(mk(1'b0, 32'd5, 48'd0));
    pending_updates.push_back(mk(1'b0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    pending_updates.push_back(mk(1'b1, 32'd0, 48'd1));
    pending_updates.push_back(mk(1'b0, 32'd0, 48'd7));
    pending_updates.push_back(mk(1'b1, 32'hFFFF_FFFF, 48'd9));
    pending_updates.push_back(mk(1'b0, 32'hFFFF_FFFF, 48'h5555_AAAA_5555));
    pending_updates.push_back(mk(1'b1, 32'd0, 48'd0));
    pending_updates.push_back(mk(1'b1, 32'd0, 48'd0));
    pending_updates.push_back(mk(1'b0, 32'h8000_0000, 48'h8000_0000_0000));
    idle_then_depth(7'd2);
    pending_updates.push_back(mk(1'b0, 32'd1, 48'd3));
    pending_updates.push_back(mk(1'b0, 32'hFFFF_FFFE, 48'd4));
    pending_updates.push_back(mk(1'b1, 32'd10, 48'd5));
    pending_updates.push_back(mk(1'b1, 32'd20, 48'd5));
    pending_updates.push_back(mk(1'b1, 32'd30, 48'd5));
    pending_updates.push_back(mk(1'b1, 32'd5, 48'd6));
    idle_then_depth(7'd0);
    // Fill the ask side past capacity to force capacity drops
    for (int i = 0; i < 66; i++)
      pending_updates.push_back(mk(1'b1, 32'd100 + i, 48'd1 + i));
    pending_updates.push_back(mk(1'b1, 32'd50, 48'd2));

    // Random phases across depth settings; pause the sender once mid-phase
    foreach (depths[k]) begin
      idle_then_depth(depths[k]);
      for (int i = 0; i < 80; i++)
        pending_updates.push_back(random_update(depths[k] > 10 ? 120 : 20));
      if (k == 2) begin
        while (pending_updates.size() > 40) @(posedge clk_i);
        hold_sender = 1'b1;
        while (start || busy || expected_reports.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
    end

    while (pending_updates.size() != 0 || start || busy || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d results, %0d with a level dropped, over six depth settings",
             reports_seen, drops_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
